### rtl/core/svt_pkg.sv
// ============================================================================
// svt_pkg
// Shared types and codes for the searchable vector table: request codes,
// status codes and the request and result bundles passed between modules.
// ============================================================================
package svt_pkg;

   // Request codes carried in the func field.
   localparam logic [3:0] OP_READ   = 4'd0;
   localparam logic [3:0] OP_WRITE  = 4'd1;
   localparam logic [3:0] OP_PUSH   = 4'd2;
   localparam logic [3:0] OP_POP    = 4'd3;
   localparam logic [3:0] OP_INSERT = 4'd4;
   localparam logic [3:0] OP_ERASE  = 4'd5;
   localparam logic [3:0] OP_FIND   = 4'd6;
   localparam logic [3:0] OP_CLEAR  = 4'd7;
   localparam logic [3:0] OP_ASSIGN = 4'd8;

   // Status codes returned with every result.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // One request transaction.
   typedef struct packed {
      logic [3:0]         func;
      logic [6:0]         position;
      logic signed [31:0] value;
      logic [6:0]         count;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic signed [31:0] read_value;
      logic [6:0]         found_position;
      logic [6:0]         size_now;
      logic [1:0]         status;
   } rsp_type;

endpackage

### rtl/core/searchable_vector_table.sv
// ============================================================================
// searchable_vector_table
// Ordered array of up to DEPTH values with positional access, push and pop,
// insert and erase with shifting, search by value, clear and assign.
// ============================================================================
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   func, position, value, count
//   rsp_      out        rsp_valid / rsp_ready   read_value, found_position,
//                                                size_now, status
//
// One request at a time. Write, push, pop, clear, rejected requests and
// unused codes go straight to the result register; read waits for the
// registered memory read. Insert moves the entries from its position up,
// unless it appends at the end, then writes count copies; erase moves the
// entries above its position down unless it removes the last one; assign
// writes count copies and find reads up to size entries, all through the
// single entry memory moving one word per cycle.
// Reset clears the fill count and the sequencer; entries need no clearing.
// A new request is taken while the previous result still waits in the
// output register; it then holds in its final state until that slot frees.
//
module searchable_vector_table #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_func,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_found_position,
   output logic [6:0]         rsp_size_now,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(DEPTH);

   svt_pkg::req_type      req;
   svt_pkg::rsp_type      done_data;
   logic                  done_valid;
   logic                  done_ready;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [VALUE_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   svt_pkg::rsp_type      rsp_ff;

   assign req.func     = req_func;
   assign req.position = req_position;
   assign req.value    = req_value;
   assign req.count    = req_count;

   svt_seq #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   svt_ram #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: loads a finished result whenever the slot is free.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_ff <= done_data;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_ff.read_value;
   assign rsp_found_position = rsp_ff.found_position;
   assign rsp_size_now       = rsp_ff.size_now;
   assign rsp_status         = rsp_ff.status;

endmodule

### rtl/core/svt_ram.sv
// ============================================================================
// svt_ram
// Entry storage: one write port and one read port, read data registered.
// ============================================================================
module svt_ram #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [VALUE_BITS-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [VALUE_BITS-1:0]        rd_data
);

   logic [VALUE_BITS-1:0] mem_ff [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/svt_seq.sv
// ============================================================================
// svt_seq
// Request sequencer: decodes a request, checks its bounds, keeps the fill
// count and walks the entry memory for reads, shifts, fills and searches.
// ============================================================================
module svt_seq #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  svt_pkg::req_type           req,
   output logic                       done_valid,
   input  logic                       done_ready,
   output svt_pkg::rsp_type           done_data,
   output logic                       ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
   output logic [VALUE_BITS-1:0]      ram_wr_data,
   output logic                       ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
   input  logic [VALUE_BITS-1:0]      ram_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = ((CW > 7) ? CW : 7) + 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_RDWAIT = 6'b000010,
      S_SHIFT  = 6'b000100,
      S_FILL   = 6'b001000,
      S_SCAN   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic [AW-1:0]         wr_idx_ff, wr_idx_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic                  pend_ff, pend_in;
   logic                  up_ff, up_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   svt_pkg::rsp_type      res_ff, res_in;

   logic [63:0]           val_wide;
   logic [VALUE_BITS-1:0] val_req;
   logic [EW-1:0]         pos_e, cnt_e, fill_e, ins_sum, erase_moves;

   // The input value is sign-extended, then cut to the stored width.
   assign val_wide    = 64'(req.value);
   assign val_req     = val_wide[VALUE_BITS-1:0];
   assign pos_e       = EW'(req.position);
   assign cnt_e       = EW'(req.count);
   assign fill_e      = EW'(fill_ff);
   assign ins_sum     = fill_e + cnt_e;
   assign erase_moves = fill_e - pos_e - EW'(1);

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done_data  = res_ff;

   // Next-state logic and memory port control.
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      dst_in    = dst_ff;
      rem_in    = rem_ff;
      pend_in   = pend_ff;
      up_in     = up_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      res_in    = res_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_idx_ff;
      ram_wr_data = val_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in                = val_req;
               cnt_in                = req.count;
               pend_in               = 1'b0;
               res_in.read_value     = '0;
               res_in.found_position = '0;
               res_in.status         = svt_pkg::ST_OK;
               state_in              = S_DONE;
               case (req.func)
                  svt_pkg::OP_READ: begin
                     if (pos_e < fill_e) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_e[AW-1:0];
                        state_in    = S_RDWAIT;
                     end else begin
                        res_in.status = svt_pkg::ST_RANGE;
                     end
                  end
                  svt_pkg::OP_WRITE: begin
                     if (pos_e < fill_e) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = pos_e[AW-1:0];
                        ram_wr_data = val_req;
                     end else begin
                        res_in.status = svt_pkg::ST_RANGE;
                     end
                  end
                  svt_pkg::OP_PUSH: begin
                     if (fill_e < EW'(DEPTH)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = fill_e[AW-1:0];
                        ram_wr_data = val_req;
                        fill_in     = fill_ff + CW'(1);
                     end else begin
                        res_in.status = svt_pkg::ST_FULL;
                     end
                  end
                  svt_pkg::OP_POP: begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - CW'(1);
                     end else begin
                        res_in.status = svt_pkg::ST_EMPTY;
                     end
                  end
                  svt_pkg::OP_INSERT: begin
                     if (pos_e > fill_e) begin
                        res_in.status = svt_pkg::ST_RANGE;
                     end else if (ins_sum > EW'(DEPTH)) begin
                        res_in.status = svt_pkg::ST_FULL;
                     end else begin
                        fill_in   = CW'(ins_sum);
                        wr_idx_in = pos_e[AW-1:0];
                        if (cnt_e == '0) begin
                           state_in = S_DONE;
                        end else if (pos_e == fill_e) begin
                           // Appending at the end: nothing to move.
                           rem_in   = CW'(cnt_e);
                           state_in = S_FILL;
                        end else begin
                           // Move the tail up, highest entry first.
                           rd_idx_in = AW'(fill_e - EW'(1));
                           rem_in    = CW'(fill_e - pos_e);
                           up_in     = 1'b1;
                           state_in  = S_SHIFT;
                        end
                     end
                  end
                  svt_pkg::OP_ERASE: begin
                     if (fill_ff == '0) begin
                        res_in.status = svt_pkg::ST_EMPTY;
                     end else if (pos_e >= fill_e) begin
                        res_in.status = svt_pkg::ST_RANGE;
                     end else begin
                        fill_in = fill_ff - CW'(1);
                        if (erase_moves != '0) begin
                           // Move the tail down, lowest entry first.
                           rd_idx_in = AW'(pos_e + EW'(1));
                           rem_in    = CW'(erase_moves);
                           up_in     = 1'b0;
                           state_in  = S_SHIFT;
                        end
                     end
                  end
                  svt_pkg::OP_FIND: begin
                     res_in.found_position = 7'(fill_ff);
                     rd_idx_in             = '0;
                     rem_in                = fill_ff;
                     state_in              = S_SCAN;
                  end
                  svt_pkg::OP_CLEAR: begin
                     fill_in = '0;
                  end
                  svt_pkg::OP_ASSIGN: begin
                     if (cnt_e > EW'(DEPTH)) begin
                        res_in.status = svt_pkg::ST_FULL;
                     end else begin
                        fill_in   = CW'(cnt_e);
                        wr_idx_in = '0;
                        rem_in    = CW'(cnt_e);
                        if (cnt_e != '0) begin
                           state_in = S_FILL;
                        end
                     end
                  end
                  default: begin
                     res_in.status = svt_pkg::ST_OK;
                  end
               endcase
               res_in.size_now = 7'(fill_in);
            end
         end

         S_RDWAIT: begin
            res_in.read_value = 32'(64'($signed(ram_rd_data)));
            state_in          = S_DONE;
         end

         // Streaming move: the word read last cycle is written to its new place
         // while the next word is read.
         S_SHIFT: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (rem_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff;
               pend_in     = 1'b1;
               rem_in      = rem_ff - CW'(1);
               if (up_ff) begin
                  dst_in    = AW'(EW'(rd_idx_ff) + EW'(cnt_ff));
                  rd_idx_in = rd_idx_ff - AW'(1);
               end else begin
                  dst_in    = rd_idx_ff - AW'(1);
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (up_ff) begin
                  rem_in   = CW'(cnt_ff);
                  state_in = S_FILL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         // Write copies of the value, one entry per cycle.
         S_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_idx_ff;
            ram_wr_data = val_ff;
            wr_idx_in   = wr_idx_ff + AW'(1);
            rem_in      = rem_ff - CW'(1);
            if (rem_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end

         // Search from the lowest entry; stop at the first match.
         S_SCAN: begin
            if (pend_ff && (ram_rd_data == val_ff)) begin
               res_in.found_position = 7'(dst_ff);
               pend_in               = 1'b0;
               state_in              = S_DONE;
            end else if (rem_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff;
               pend_in     = 1'b1;
               dst_in      = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + AW'(1);
               rem_in      = rem_ff - CW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      dst_ff    <= dst_in;
      rem_ff    <= rem_in;
      up_ff     <= up_in;
      cnt_ff    <= cnt_in;
      val_ff    <= val_in;
      res_ff    <= res_in;
   end

endmodule

### dv/svt_checker.sv
// ============================================================================
// svt_checker
// Watches both channels of the searchable vector table, keeps its own copy
// of the stored entries and the fill count, works out the result of every
// accepted request and compares it, field by field, with the result that
// comes back. It reports the failure count, the results still owed and the
// number of stored entries it currently predicts.
// ============================================================================
module svt_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [3:0]         req_func,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_count,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_read_value,
   input  logic [6:0]         rsp_found_position,
   input  logic [6:0]         rsp_size_now,
   input  logic [1:0]         rsp_status,
   output int                 error_count,
   output int                 pending,
   output int                 stored_size
);

   localparam int SLOT_COUNT   = 64;
   localparam int REPORT_LIMIT = 10;

   // Predicted contents of the array and the number of live entries.
   logic [31:0] slots [SLOT_COUNT];
   int          fill;

   // Results owed by the block, oldest first.
   svt_pkg::rsp_type results_owed [$];

   // Applies one request to the predicted array and returns its result.
   function automatic svt_pkg::rsp_type serve_request(logic [3:0] op, logic [6:0] pos_in,
                                                      logic [31:0] val, logic [6:0] cnt_in);
      svt_pkg::rsp_type res;
      int      pos;
      int      cnt;
      int      i;
      pos = pos_in;
      cnt = cnt_in;
      res = '0;
      res.status = svt_pkg::ST_OK;
      case (op)
         svt_pkg::OP_READ: begin
            if (pos < fill) res.read_value = slots[pos];
            else res.status = svt_pkg::ST_RANGE;
         end
         svt_pkg::OP_WRITE: begin
            if (pos < fill) slots[pos] = val;
            else res.status = svt_pkg::ST_RANGE;
         end
         svt_pkg::OP_PUSH: begin
            if (fill < SLOT_COUNT) begin
               slots[fill] = val;
               fill++;
            end else begin
               res.status = svt_pkg::ST_FULL;
            end
         end
         svt_pkg::OP_POP: begin
            if (fill > 0) fill--;
            else res.status = svt_pkg::ST_EMPTY;
         end
         svt_pkg::OP_INSERT: begin
            if (pos > fill) begin
               res.status = svt_pkg::ST_RANGE;
            end else if (fill + cnt > SLOT_COUNT) begin
               res.status = svt_pkg::ST_FULL;
            end else begin
               // Move the tail up first, then fill the opened gap.
               for (i = fill; i > pos; i--) slots[i - 1 + cnt] = slots[i - 1];
               for (i = 0; i < cnt; i++) slots[pos + i] = val;
               fill += cnt;
            end
         end
         svt_pkg::OP_ERASE: begin
            if (fill == 0) begin
               res.status = svt_pkg::ST_EMPTY;
            end else if (pos >= fill) begin
               res.status = svt_pkg::ST_RANGE;
            end else begin
               for (i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
               fill--;
            end
         end
         svt_pkg::OP_FIND: begin
            // Scanning downward leaves the lowest match as the answer.
            res.found_position = 7'(fill);
            for (i = fill - 1; i >= 0; i--) begin
               if (slots[i] == val) res.found_position = 7'(i);
            end
         end
         svt_pkg::OP_CLEAR: begin
            fill = 0;
         end
         svt_pkg::OP_ASSIGN: begin
            if (cnt > SLOT_COUNT) begin
               res.status = svt_pkg::ST_FULL;
            end else begin
               for (i = 0; i < cnt; i++) slots[i] = val;
               fill = cnt;
            end
         end
         default: begin
         end
      endcase
      res.size_now = 7'(fill);
      return res;
   endfunction

   // Results are retired before new requests are added, since a result
   // accepted at an edge always belongs to an earlier request.
   always @(posedge clock) begin
      svt_pkg::rsp_type seen;
      svt_pkg::rsp_type owed;
      svt_pkg::rsp_type fresh;
      if (reset) begin
         fill = 0;
         results_owed.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.read_value     = rsp_read_value;
            seen.found_position = rsp_found_position;
            seen.size_now       = rsp_size_now;
            seen.status         = rsp_status;
            if (results_owed.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: result transaction with nothing outstanding: %p", $time, seen);
            end else begin
               owed = results_owed.pop_front();
               if (seen.read_value !== owed.read_value ||
                   seen.found_position !== owed.found_position ||
                   seen.size_now !== owed.size_now ||
                   seen.status !== owed.status) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: result mismatch, expected %p, got %p", $time, owed, seen);
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh = serve_request(req_func, req_position, req_value, req_count);
            results_owed.insert(results_owed.size(), fresh);
         end
      end
      pending     = results_owed.size();
      stored_size = fill;
   end

endmodule

### dv/searchable_vector_table_tb.sv
// ============================================================================
// searchable_vector_table_tb
// Drives requests into the searchable vector table and drains its results
// under random idling on both sides. A short directed run covers the range,
// full and empty rejections, shifting inserts and erases, repeated matches
// and unused codes; random requests follow in three idling phases. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ============================================================================
module searchable_vector_table_tb;

   localparam int TABLE_DEPTH     = 64;
   localparam int ITEMS_PER_PHASE = 667;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 200;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic [3:0]         req_func     = svt_pkg::OP_READ;
   logic [6:0]         req_position = '0;
   logic signed [31:0] req_value    = '0;
   logic [6:0]         req_count    = '0;
   logic               rsp_ready    = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic [6:0]         rsp_found_position;
   logic [6:0]         rsp_size_now;
   logic [1:0]         rsp_status;

   int                 error_count;
   int                 pending;
   int                 stored_size;

   // Idling rates in percent, and a request for a long receiver hold-off.
   int                 send_idle_pct    = 14;
   int                 recv_idle_pct    = 63;
   bit                 hold_off_request = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   searchable_vector_table dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_count          (req_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_size_now       (rsp_size_now),
      .rsp_status         (rsp_status)
   );

   svt_checker check_unit (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_value          (req_value),
      .req_count          (req_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_size_now       (rsp_size_now),
      .rsp_status         (rsp_status),
      .error_count        (error_count),
      .pending            (pending),
      .stored_size        (stored_size)
   );

   // Offers one request transaction, with random idle cycles ahead of it,
   // and returns at the falling edge after it has been accepted.
   task automatic offer(logic [3:0] f, logic [6:0] p, logic [31:0] v, logic [6:0] c);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= f;
      req_position <= p;
      req_value    <= v;
      req_count    <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops sending until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Values mostly come from a small pool so that finds hit, often more
   // than once; the rest are fully random words.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(99, 0) >= 60) return $urandom;
      case ($urandom_range(7, 0))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         5: return 32'h0000_0002;
         6: return 32'h5A5A_5A5A;
         default: return 32'hA5A5_A5A5;
      endcase
   endfunction

   // One random request. Positions mostly fall within the current size and
   // counts are mostly small, so that shifts and finds stay short.
   task automatic random_request();
      int         pick;
      int         sel;
      logic [3:0] f;
      logic [6:0] p;
      logic [6:0] c;
      pick = $urandom_range(99, 0);
      if (pick < 14) f = svt_pkg::OP_READ;
      else if (pick < 26) f = svt_pkg::OP_WRITE;
      else if (pick < 44) f = (stored_size >= 48) ? svt_pkg::OP_POP : svt_pkg::OP_PUSH;
      else if (pick < 52) f = svt_pkg::OP_POP;
      else if (pick < 63) f = svt_pkg::OP_INSERT;
      else if (pick < 73) f = svt_pkg::OP_ERASE;
      else if (pick < 88) f = svt_pkg::OP_FIND;
      else if (pick < 90) f = svt_pkg::OP_CLEAR;
      else if (pick < 96) f = svt_pkg::OP_ASSIGN;
      else f = 4'($urandom_range(15, 9));
      sel = $urandom_range(99, 0);
      if (sel < 85) p = 7'($urandom_range(stored_size, 0));
      else if (sel < 97) p = 7'($urandom_range(TABLE_DEPTH, 0));
      else p = 7'($urandom_range(127, 0));
      sel = $urandom_range(99, 0);
      if (sel < 80) c = 7'($urandom_range(4, 0));
      else if (sel < 97) c = 7'($urandom_range(TABLE_DEPTH, 0));
      else c = 7'($urandom_range(127, TABLE_DEPTH + 1));
      offer(f, p, pick_value(), c);
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int k;
      bit hold_off_done;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            hold_off_done = 1'b1;
            for (k = 0; k < HOLD_OFF_CYCLES; k++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Stimulus and verdict.
   initial begin
      int phase;
      int n;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: rejections and a search on an empty array first.
      offer(svt_pkg::OP_POP,    7'd0,   32'd0,          7'd0);
      offer(svt_pkg::OP_ERASE,  7'd0,   32'd0,          7'd0);
      offer(svt_pkg::OP_READ,   7'd0,   32'd0,          7'd0);
      offer(svt_pkg::OP_FIND,   7'd0,   32'd5,          7'd0);
      // Fill with the extreme values, one of them twice.
      offer(svt_pkg::OP_PUSH,   7'd0,   32'h8000_0000,  7'd0);
      offer(svt_pkg::OP_PUSH,   7'd0,   32'h7FFF_FFFF,  7'd0);
      offer(svt_pkg::OP_PUSH,   7'd0,   32'hFFFF_FFFF,  7'd0);
      offer(svt_pkg::OP_PUSH,   7'd0,   32'h8000_0000,  7'd0);
      offer(svt_pkg::OP_READ,   7'd3,   32'd0,          7'd0);
      offer(svt_pkg::OP_READ,   7'd64,  32'd0,          7'd0);
      offer(svt_pkg::OP_WRITE,  7'd1,   32'd0,          7'd0);
      offer(svt_pkg::OP_WRITE,  7'd4,   32'd9,          7'd0);
      // The lowest of several matches, then a value that is absent.
      offer(svt_pkg::OP_FIND,   7'd0,   32'h8000_0000,  7'd0);
      offer(svt_pkg::OP_FIND,   7'd0,   32'd12345,      7'd0);
      // Insert past the end, with no copies, with copies, and overflowing.
      offer(svt_pkg::OP_INSERT, 7'd5,   32'd7,          7'd1);
      offer(svt_pkg::OP_INSERT, 7'd2,   32'd7,          7'd0);
      offer(svt_pkg::OP_INSERT, 7'd2,   32'd7,          7'd3);
      offer(svt_pkg::OP_INSERT, 7'd0,   32'd7,          7'd64);
      // Erase from the middle and at the end.
      offer(svt_pkg::OP_ERASE,  7'd3,   32'd0,          7'd0);
      offer(svt_pkg::OP_ERASE,  7'd5,   32'd0,          7'd0);
      offer(4'd15,              7'd127, 32'h1234_5678,  7'd127);
      // Fill completely, then reject a push and an oversized assign.
      offer(svt_pkg::OP_ASSIGN, 7'd0,   32'h7FFF_FFFF,  7'd64);
      offer(svt_pkg::OP_PUSH,   7'd0,   32'd1,          7'd0);
      offer(svt_pkg::OP_INSERT, 7'd64,  32'd1,          7'd0);
      offer(svt_pkg::OP_ASSIGN, 7'd0,   32'd1,          7'd127);
      offer(svt_pkg::OP_FIND,   7'd0,   32'h7FFF_FFFF,  7'd0);
      offer(svt_pkg::OP_CLEAR,  7'd0,   32'd0,          7'd0);

      // Random requests in three idling phases, draining between them.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Stall the receiver while requests keep coming, to fill the block.
            if (phase == 0 && n == 100) hold_off_request = 1'b1;
            random_request();
         end
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Backstop in case the block hangs.
   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
